>>> hw/rtl/smpq_pkg.sv
// ============================================================================
// smpq_pkg
// Shared types and constants for the stable max-priority queue.
// ============================================================================
package smpq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH   = 16;
   localparam int DEFAULT_PRIORITY_BITS = 8;

   localparam int VALUE_W     = 32;
   localparam int PRIO_PORT_W = 8;
   localparam int STATUS_W    = 2;
   localparam int OCC_W       = 5;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

endpackage

>>> hw/rtl/smpq_ctrl.sv
// ============================================================================
// smpq_ctrl
// Controller: sequences capture and execution of one item at a time and owns
// the result handshake.
// ============================================================================
module smpq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output smpq_pkg::dp_cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic capture;
   logic execute;

   assign req_ready = (state_ff == S_IDLE);
   assign capture   = req_valid && req_ready;
   assign execute   = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (capture) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (execute) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = capture;
   assign cmd.execute = execute;

endmodule

>>> hw/rtl/smpq_datapath.sv
// ============================================================================
// smpq_datapath
// Datapath: a row of sorted slots that compare against the new priority in
// parallel and shift on insert or remove, plus the result register.
// ============================================================================
module smpq_datapath #(
   parameter int QUEUE_DEPTH   = smpq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int PRIORITY_BITS = smpq_pkg::DEFAULT_PRIORITY_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  smpq_pkg::dp_cmd_type                cmd,
   input  logic                                req_action,
   input  logic [smpq_pkg::VALUE_W-1:0]        req_in_value,
   input  logic [smpq_pkg::PRIO_PORT_W-1:0]    req_in_priority,
   output logic [smpq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [smpq_pkg::VALUE_W-1:0]        rsp_out_value,
   output logic [smpq_pkg::PRIO_PORT_W-1:0]    rsp_out_priority,
   output logic [smpq_pkg::OCC_W-1:0]          rsp_occupancy
);

   localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
   localparam int PrioW = (PRIORITY_BITS < smpq_pkg::PRIO_PORT_W) ?
                          PRIORITY_BITS : smpq_pkg::PRIO_PORT_W;

   logic                            action_ff;
   logic [smpq_pkg::VALUE_W-1:0]    value_ff;
   logic [PrioW-1:0]                prio_ff;

   logic [smpq_pkg::VALUE_W-1:0]    slot_value_ff [QUEUE_DEPTH];
   logic [PrioW-1:0]                slot_prio_ff  [QUEUE_DEPTH];
   logic [smpq_pkg::VALUE_W-1:0]    slot_value_in [QUEUE_DEPTH];
   logic [PrioW-1:0]                slot_prio_in  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]          keep;

   logic [CntW-1:0]                 count_ff;
   logic [CntW-1:0]                 count_in;
   logic                            full;
   logic                            empty;
   logic                            update;

   logic [smpq_pkg::STATUS_W-1:0]   status_ff;
   logic [smpq_pkg::STATUS_W-1:0]   status_in;
   logic [smpq_pkg::VALUE_W-1:0]    out_value_ff;
   logic [smpq_pkg::VALUE_W-1:0]    out_value_in;
   logic [PrioW-1:0]                out_prio_ff;
   logic [PrioW-1:0]                out_prio_in;
   logic [smpq_pkg::OCC_W-1:0]      occ_ff;

   assign full  = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         keep[i] = (CntW'(i) < count_ff) && (slot_prio_ff[i] >= prio_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_value_in[i] = slot_value_ff[i];
         slot_prio_in[i]  = slot_prio_ff[i];
         if (action_ff == smpq_pkg::ACT_INSERT) begin
            if (!keep[i]) begin
               if (i == 0) begin
                  slot_value_in[i] = value_ff;
                  slot_prio_in[i]  = prio_ff;
               end else if (keep[i-1]) begin
                  slot_value_in[i] = value_ff;
                  slot_prio_in[i]  = prio_ff;
               end else begin
                  slot_value_in[i] = slot_value_ff[i-1];
                  slot_prio_in[i]  = slot_prio_ff[i-1];
               end
            end
         end else if (i < QUEUE_DEPTH - 1) begin
            slot_value_in[i] = slot_value_ff[i+1];
            slot_prio_in[i]  = slot_prio_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      status_in    = smpq_pkg::ST_OK;
      out_value_in = '0;
      out_prio_in  = '0;
      update       = 1'b0;
      if (action_ff == smpq_pkg::ACT_INSERT) begin
         if (full) begin
            status_in = smpq_pkg::ST_FULL;
         end else begin
            update   = 1'b1;
            count_in = count_ff + CntW'(1);
         end
      end else begin
         if (empty) begin
            status_in = smpq_pkg::ST_EMPTY;
         end else begin
            update       = 1'b1;
            count_in     = count_ff - CntW'(1);
            out_value_in = slot_value_ff[0];
            out_prio_in  = slot_prio_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         value_ff  <= req_in_value;
         prio_ff   <= req_in_priority[PrioW-1:0];
      end
      if (cmd.execute) begin
         status_ff    <= status_in;
         out_value_ff <= out_value_in;
         out_prio_ff  <= out_prio_in;
         occ_ff       <= smpq_pkg::OCC_W'(count_in);
         if (update) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               slot_value_ff[i] <= slot_value_in[i];
               slot_prio_ff[i]  <= slot_prio_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_out_value    = out_value_ff;
   assign rsp_out_priority = smpq_pkg::PRIO_PORT_W'(out_prio_ff);
   assign rsp_occupancy    = occ_ff;

endmodule

>>> hw/rtl/stable_max_priority_queue.sv
// With the output register free, an accepted item is captured, then executed into the registered result.
// An item is accepted only while no other is in progress, so the capture step and the
// parallel compare-and-shift update of the slot row finish before the next item is taken.
// A waiting result does not block acceptance of the next item; its update waits for the result.
// Reset clears the entry count and the handshake; slot contents are not cleared.
// ============================================================================
// stable_max_priority_queue
// Bounded max-priority queue with stable sorted insertion and head removal.
// ============================================================================
module stable_max_priority_queue #(
   parameter int QUEUE_DEPTH   = smpq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int PRIORITY_BITS = smpq_pkg::DEFAULT_PRIORITY_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [smpq_pkg::VALUE_W-1:0]        req_in_value,
   input  logic [smpq_pkg::PRIO_PORT_W-1:0]    req_in_priority,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [smpq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [smpq_pkg::VALUE_W-1:0]        rsp_out_value,
   output logic [smpq_pkg::PRIO_PORT_W-1:0]    rsp_out_priority,
   output logic [smpq_pkg::OCC_W-1:0]          rsp_occupancy
);

   smpq_pkg::dp_cmd_type cmd;

   smpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   smpq_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_action       (req_action),
      .req_in_value     (req_in_value),
      .req_in_priority  (req_in_priority),
      .rsp_status       (rsp_status),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_priority (rsp_out_priority),
      .rsp_occupancy    (rsp_occupancy)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in progress");

   a_result_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without an item in progress");

   a_empty_occupancy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == smpq_pkg::ST_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty status with nonzero occupancy");

   a_full_occupancy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == smpq_pkg::ST_FULL)
         |-> (rsp_occupancy == smpq_pkg::OCC_W'(QUEUE_DEPTH)))
      else $error("full status with wrong occupancy");
`endif

endmodule
